// ----- rtl/iso8583_message_unpacker_macros.svh -----
// assertion helpers for the message unpacker
`ifndef ISO8583_MESSAGE_UNPACKER_MACROS_SVH
`define ISO8583_MESSAGE_UNPACKER_MACROS_SVH

// same-cycle implication, checked outside reset
`define IMU_ASSERT_IMPLIES(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("unpacker check failed: same-cycle rule");

// next-cycle implication, checked outside reset
`define IMU_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("unpacker check failed: next-cycle rule");

`endif

// ----- rtl/iso8583u_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// iso8583u_pkg
// shared types, codes and helpers of the iso 8583 message unpacker
// ---------------------------------------------------------------------------
package iso8583u_pkg;

   // field types
   localparam logic [2:0] TYPE_ASCII  = 3'd0;
   localparam logic [2:0] TYPE_BCD    = 3'd1;
   localparam logic [2:0] TYPE_BIN    = 3'd2;
   localparam logic [2:0] TYPE_BITMAP = 3'd3;
   localparam logic [2:0] TYPE_MAC    = 3'd4;

   // field formats
   localparam logic [1:0] FMT_FIXED  = 2'd0;
   localparam logic [1:0] FMT_LLVAR  = 2'd1;
   localparam logic [1:0] FMT_LLLVAR = 2'd2;

   // request kinds
   localparam logic REQ_TABLE = 1'b0;
   localparam logic REQ_MSG   = 1'b1;

   // register indexes
   localparam logic [1:0] CSR_BITMAP_FIELD = 2'd0;
   localparam logic [1:0] CSR_MAC_FIELD    = 2'd1;
   localparam logic [1:0] CSR_MAC_ENABLE   = 2'd2;
   localparam logic [1:0] CSR_FIELD_TOTAL  = 2'd3;

   // result kinds
   localparam logic [1:0] KIND_CHAR      = 2'd0;
   localparam logic [1:0] KIND_OK        = 2'd1;
   localparam logic [1:0] KIND_MISMATCH  = 2'd2;
   localparam logic [1:0] KIND_LEN_ERROR = 2'd3;

   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_HEX_ALPHA = 8'h37;

   typedef enum logic [2:0] {
      PH_IDLE       = 3'd0,
      PH_HDR_A      = 3'd1,
      PH_HDR_B      = 3'd2,
      PH_HDR_B_STOP = 3'd3,
      PH_DATA       = 3'd4,
      PH_DONE       = 3'd5,
      PH_ERROR      = 3'd6,
      PH_OVER       = 3'd7
   } phase_type;

   typedef enum logic [4:0] {
      ST_READY, ST_BEGIN, ST_SEARCH, ST_LOAD, ST_START, ST_FAIL, ST_DISPATCH,
      ST_HDR_HI, ST_HDR_LO, ST_HDR_END, ST_DATA, ST_HEX1, ST_HEX2, ST_RAW,
      ST_BCD1, ST_BCD2, ST_FIELD_END, ST_LAST
   } state_type;

   typedef enum logic [2:0] {
      EMIT_FAIL, EMIT_HEX_HI, EMIT_HEX_LO, EMIT_RAW, EMIT_BCD_HI, EMIT_BCD_LO,
      EMIT_STATUS
   } emit_sel_type;

   typedef enum logic [1:0] {
      CLS_RAW, CLS_HEX, CLS_BCD
   } cls_type;

   typedef struct packed {
      logic        req_type;
      logic [6:0]  def_index;
      logic        def_present;
      logic [2:0]  def_type;
      logic [1:0]  def_format;
      logic [13:0] def_length;
      logic [7:0]  msg_byte;
      logic        last_byte;
   } req_payload_type;

   typedef struct packed {
      logic [1:0] out_kind;
      logic [6:0] field_number;
      logic [7:0] out_char;
      logic       field_end;
   } rsp_payload_type;

   typedef struct packed {
      logic         table_wr;
      logic         capture;
      logic         msg_start;
      logic         srch_init;
      logic         srch_next;
      logic         srch_step;
      logic         set_cur;
      logic         load_entry;
      logic         start_data;
      logic         hdr_init;
      logic         hdr_nib;
      logic         hdr_lo;
      logic         begin_hdr;
      logic         data_step;
      logic         emit;
      emit_sel_type emit_sel;
      logic         set_phase;
      phase_type    phase_val;
   } cmd_type;

   typedef struct packed {
      phase_type phase;
      logic      req_is_msg;
      logic      slot_free;
      logic      srch_done;
      logic      srch_found;
      logic      start_fail;
      logic      start_hdr;
      logic      hdr_fmt2;
      logic      hdr_stop;
      logic      hdr_bad;
      cls_type   data_cls;
      logic      digits_zero;
      logic      bytes_zero;
      logic      mac_done;
      logic      last;
      logic      error_seen;
   } status_type;

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      if (nib < 4'd10) begin
         hex_char = CHAR_ZERO + {4'd0, nib};
      end else begin
         hex_char = CHAR_HEX_ALPHA + {4'd0, nib};
      end
   endfunction

endpackage

// ----- rtl/iso8583u_ram.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// iso8583u_ram
// simple dual-port ram, one write port and one registered read port
// ---------------------------------------------------------------------------
module iso8583u_ram #(
   parameter int WIDTH = 20,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/iso8583u_dpath.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// iso8583u_dpath
// field table, parse registers, field search and result register
// ---------------------------------------------------------------------------
module iso8583u_dpath #(
   parameter int MAX_FIELDS = 128,
   parameter int MAX_BITMAP_BYTES = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  iso8583u_pkg::req_payload_type req_data,
   input  logic                          csr_write,
   input  logic [1:0]                    csr_index,
   input  logic [7:0]                    csr_wdata,
   input  iso8583u_pkg::cmd_type         cmd,
   output iso8583u_pkg::status_type      status,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output iso8583u_pkg::rsp_payload_type rsp_data
);

   localparam int IW  = $clog2(MAX_FIELDS);
   localparam int PW  = MAX_BITMAP_BYTES * 8;
   localparam int PIW = $clog2(PW);

   // configuration
   logic [6:0] bitmap_field_ff, mac_field_ff;
   logic       mac_enable_ff;
   logic [7:0] field_total_ff;

   // table bookkeeping
   logic [MAX_FIELDS-1:0] valid_ff, valid_in, present_ff, present_in;
   logic [PW-1:0]         presence_ff, presence_in;

   logic [6:0]  cur_field_ff, cur_field_in;
   logic [19:0] cur_entry_ff, cur_entry_in;
   iso8583u_pkg::phase_type phase_ff, phase_in;
   logic [13:0] hv_ff, hv_in, bytes_left_ff, bytes_left_in, digits_left_ff, digits_left_in;
   logic        error_seen_ff, error_seen_in, stop_ff, stop_in;
   logic [7:0]  byte_ff, byte_in;
   logic        last_ff, last_in;
   logic [4:0]  srch_blk_ff, srch_blk_in;
   logic [7:0]  srch_from_ff, srch_from_in;
   logic        rd_valid_ff, rd_valid_in;
   logic        rsp_valid_ff, rsp_valid_in;
   iso8583u_pkg::rsp_payload_type rsp_data_ff, rsp_data_in;

   logic [19:0] new_entry, rd_data;
   logic        table_wr_ok;
   logic [7:0]  total;
   logic [7:0]  hit, cand;
   logic [2:0]  hit_sel;
   logic [6:0]  hit_idx;
   logic        is_bm;
   logic        cur_p;
   logic [2:0]  cur_t;
   logic [1:0]  cur_f;
   logic [13:0] cur_len;
   logic        slot_free;
   logic [3:0]  nib;
   logic [16:0] hv_mul;
   logic [13:0] begin_len;
   logic        begin_bcd;
   logic [14:0] begin_half;
   logic [3:0]  bm_byte;
   logic [13:0] bm_off;

   assign new_entry = {req_data.def_present, req_data.def_type, req_data.def_format,
                       req_data.def_length};
   assign table_wr_ok = cmd.table_wr && ({1'b0, req_data.def_index} < 8'(MAX_FIELDS));

   assign cur_p   = cur_entry_ff[19];
   assign cur_t   = cur_entry_ff[18:16];
   assign cur_f   = cur_entry_ff[15:14];
   assign cur_len = cur_entry_ff[13:0];
   assign is_bm   = cur_field_ff == bitmap_field_ff;
   assign total   = (field_total_ff > 8'(MAX_FIELDS)) ? 8'(MAX_FIELDS) : field_total_ff;
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   // eight candidates of the field search per cycle
   always_comb begin
      logic [7:0] idx8;
      logic [6:0] i7, j7;
      logic       pres, bit_on, brk;
      hit = '0;
      cand = '0;
      for (int s = 0; s < 8; s++) begin
         idx8 = {1'b0, srch_blk_ff[3:0], 3'(s)};
         i7 = idx8[6:0];
         j7 = i7 - 7'd1;
         pres = (idx8 < 8'(MAX_FIELDS)) ? present_ff[i7[IW-1:0]] : 1'b0;
         bit_on = ({1'b0, j7} < 8'(PW)) ? presence_ff[j7[PIW-1:0]] : 1'b0;
         brk = 1'b0;
         if (i7 < bitmap_field_ff) begin
            cand[s] = pres;
         end else if (i7 == bitmap_field_ff) begin
            cand[s] = 1'b1;
         end else begin
            cand[s] = (idx8 < total) && pres && bit_on;
            brk = idx8 >= total;
         end
         hit[s] = (idx8 >= srch_from_ff) && (cand[s] || brk);
      end
      hit_sel = 3'd0;
      for (int s = 7; s >= 0; s--) begin
         if (hit[s]) begin
            hit_sel = 3'(s);
         end
      end
   end

   assign hit_idx = {srch_blk_ff[3:0], hit_sel};

   iso8583u_ram #(.WIDTH(20), .DEPTH(MAX_FIELDS)) u_table (
      .clock   (clock),
      .wr_en   (table_wr_ok),
      .wr_addr (req_data.def_index[IW-1:0]),
      .wr_data (new_entry),
      .rd_addr (hit_idx[IW-1:0]),
      .rd_data (rd_data)
   );

   assign nib = cmd.hdr_lo ? byte_ff[3:0] : byte_ff[7:4];
   assign hv_mul = (17'(hv_ff) << 3) + (17'(hv_ff) << 1) + 17'(nib);
   assign begin_len = cmd.begin_hdr ? hv_ff : cur_len;
   assign begin_bcd = !is_bm && (cur_t == iso8583u_pkg::TYPE_BCD);
   assign begin_half = (15'(begin_len) + 15'd1) >> 1;
   assign bm_off = cur_len - bytes_left_ff;
   assign bm_byte = bm_off[3:0];

   always_comb begin
      valid_in = valid_ff;
      present_in = present_ff;
      presence_in = presence_ff;
      cur_field_in = cur_field_ff;
      cur_entry_in = cur_entry_ff;
      phase_in = phase_ff;
      hv_in = hv_ff;
      bytes_left_in = bytes_left_ff;
      digits_left_in = digits_left_ff;
      error_seen_in = error_seen_ff;
      stop_in = stop_ff;
      byte_in = byte_ff;
      last_in = last_ff;
      srch_blk_in = srch_blk_ff;
      srch_from_in = srch_from_ff;
      rd_valid_in = ({1'b0, hit_idx} < 8'(MAX_FIELDS)) ? valid_ff[hit_idx[IW-1:0]] : 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in = rsp_data_ff;

      if (table_wr_ok) begin
         valid_in[req_data.def_index[IW-1:0]] = 1'b1;
         present_in[req_data.def_index[IW-1:0]] = req_data.def_present;
         if (req_data.def_index == cur_field_ff) begin
            cur_entry_in = new_entry;
         end
      end
      if (cmd.capture) begin
         byte_in = req_data.msg_byte;
         last_in = req_data.last_byte;
      end
      if (cmd.msg_start) begin
         presence_in = '0;
         error_seen_in = 1'b0;
      end
      if (cmd.srch_init) begin
         srch_from_in = cmd.srch_next ? ({1'b0, cur_field_ff} + 8'd1) : 8'd0;
         srch_blk_in = srch_from_in[7:3];
      end
      if (cmd.srch_step) begin
         srch_blk_in = srch_blk_ff + 5'd1;
      end
      if (cmd.set_cur) begin
         cur_field_in = hit_idx;
         hv_in = '0;
      end
      if (cmd.load_entry) begin
         cur_entry_in = rd_valid_ff ? rd_data : '0;
      end
      if (cmd.start_data || cmd.begin_hdr) begin
         phase_in = iso8583u_pkg::PH_DATA;
         if (begin_bcd) begin
            digits_left_in = begin_len;
            bytes_left_in = begin_half[13:0];
         end else begin
            digits_left_in = '0;
            bytes_left_in = begin_len;
         end
      end
      if (cmd.hdr_init) begin
         stop_in = phase_ff == iso8583u_pkg::PH_HDR_B_STOP;
      end
      if (cmd.hdr_nib && !stop_ff) begin
         if (nib > 4'd9) begin
            stop_in = 1'b1;
         end else begin
            hv_in = hv_mul[13:0];
         end
      end
      if (cmd.data_step) begin
         bytes_left_in = bytes_left_ff - 14'd1;
         if (is_bm) begin
            for (int p = 0; p < PW; p++) begin
               if (bm_byte == 4'(p >> 3) && byte_ff[7 - (p & 7)]) begin
                  presence_in[p] = 1'b1;
               end
            end
         end
      end
      if (cmd.set_phase) begin
         phase_in = cmd.phase_val;
      end
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in.out_kind = iso8583u_pkg::KIND_CHAR;
         rsp_data_in.field_number = cur_field_ff;
         rsp_data_in.out_char = '0;
         rsp_data_in.field_end = 1'b0;
         unique case (cmd.emit_sel)
            iso8583u_pkg::EMIT_FAIL: begin
               rsp_data_in.out_kind = iso8583u_pkg::KIND_LEN_ERROR;
               error_seen_in = 1'b1;
            end
            iso8583u_pkg::EMIT_HEX_HI: begin
               rsp_data_in.out_char = iso8583u_pkg::hex_char(byte_ff[7:4]);
            end
            iso8583u_pkg::EMIT_HEX_LO: begin
               rsp_data_in.out_char = iso8583u_pkg::hex_char(byte_ff[3:0]);
               rsp_data_in.field_end = bytes_left_ff == '0;
            end
            iso8583u_pkg::EMIT_RAW: begin
               rsp_data_in.out_char = byte_ff;
               rsp_data_in.field_end = bytes_left_ff == '0;
            end
            iso8583u_pkg::EMIT_BCD_HI, iso8583u_pkg::EMIT_BCD_LO: begin
               rsp_data_in.out_char = iso8583u_pkg::CHAR_ZERO + {4'd0,
                  (cmd.emit_sel == iso8583u_pkg::EMIT_BCD_HI) ? byte_ff[7:4] : byte_ff[3:0]};
               rsp_data_in.field_end = digits_left_ff == 14'd1;
               digits_left_in = digits_left_ff - 14'd1;
            end
            iso8583u_pkg::EMIT_STATUS: begin
               rsp_data_in.out_kind = (phase_ff == iso8583u_pkg::PH_DONE) ?
                  iso8583u_pkg::KIND_OK : iso8583u_pkg::KIND_MISMATCH;
               rsp_data_in.field_number = '0;
            end
            default: begin
               rsp_data_in.out_kind = iso8583u_pkg::KIND_LEN_ERROR;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bitmap_field_ff <= 7'd1;
         mac_field_ff <= 7'd64;
         mac_enable_ff <= 1'b0;
         field_total_ff <= 8'd128;
      end else if (csr_write) begin
         unique case (csr_index)
            iso8583u_pkg::CSR_BITMAP_FIELD: bitmap_field_ff <= csr_wdata[6:0];
            iso8583u_pkg::CSR_MAC_FIELD:    mac_field_ff <= csr_wdata[6:0];
            iso8583u_pkg::CSR_MAC_ENABLE:   mac_enable_ff <= csr_wdata[0];
            iso8583u_pkg::CSR_FIELD_TOTAL:  field_total_ff <= csr_wdata;
            default:                        mac_enable_ff <= mac_enable_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         present_ff <= '0;
         presence_ff <= '0;
         cur_field_ff <= '0;
         cur_entry_ff <= '0;
         phase_ff <= iso8583u_pkg::PH_IDLE;
         hv_ff <= '0;
         bytes_left_ff <= '0;
         digits_left_ff <= '0;
         error_seen_ff <= 1'b0;
         stop_ff <= 1'b0;
         last_ff <= 1'b0;
         srch_blk_ff <= '0;
         srch_from_ff <= '0;
         rd_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         present_ff <= present_in;
         presence_ff <= presence_in;
         cur_field_ff <= cur_field_in;
         cur_entry_ff <= cur_entry_in;
         phase_ff <= phase_in;
         hv_ff <= hv_in;
         bytes_left_ff <= bytes_left_in;
         digits_left_ff <= digits_left_in;
         error_seen_ff <= error_seen_in;
         stop_ff <= stop_in;
         last_ff <= last_in;
         srch_blk_ff <= srch_blk_in;
         srch_from_ff <= srch_from_in;
         rd_valid_ff <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      status.phase = phase_ff;
      status.req_is_msg = req_data.req_type == iso8583u_pkg::REQ_MSG;
      status.slot_free = slot_free;
      status.srch_done = (|hit) || (srch_blk_ff[3:0] == 4'd15) || srch_blk_ff[4];
      status.srch_found = (|hit) && cand[hit_sel];
      if (is_bm) begin
         status.start_fail = !cur_p || (cur_f != iso8583u_pkg::FMT_FIXED) || (cur_len == '0)
                             || (cur_len > 14'(MAX_BITMAP_BYTES));
      end else begin
         status.start_fail = (cur_t > iso8583u_pkg::TYPE_MAC)
                             || (cur_f > iso8583u_pkg::FMT_LLLVAR)
                             || ((cur_f == iso8583u_pkg::FMT_FIXED) && (cur_len == '0));
      end
      status.start_hdr = !is_bm && (cur_f != iso8583u_pkg::FMT_FIXED);
      status.hdr_fmt2 = cur_f == iso8583u_pkg::FMT_LLLVAR;
      status.hdr_stop = stop_ff;
      status.hdr_bad = (hv_ff == '0) || (hv_ff > cur_len);
      if (is_bm) begin
         status.data_cls = iso8583u_pkg::CLS_RAW;
      end else if (cur_t == iso8583u_pkg::TYPE_BIN || cur_t == iso8583u_pkg::TYPE_MAC) begin
         status.data_cls = iso8583u_pkg::CLS_HEX;
      end else if (cur_t == iso8583u_pkg::TYPE_BCD) begin
         status.data_cls = iso8583u_pkg::CLS_BCD;
      end else begin
         status.data_cls = iso8583u_pkg::CLS_RAW;
      end
      status.digits_zero = digits_left_ff == '0;
      status.bytes_zero = bytes_left_ff == '0;
      status.mac_done = mac_enable_ff && (cur_field_ff == mac_field_ff)
                        && (cur_field_ff > bitmap_field_ff);
      status.last = last_ff;
      status.error_seen = error_seen_ff;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

endmodule

// ----- rtl/iso8583u_ctrl.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// iso8583u_ctrl
// sequencer for one request: search, field start, header, data and status
// ---------------------------------------------------------------------------
module iso8583u_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  iso8583u_pkg::status_type status,
   output iso8583u_pkg::cmd_type    cmd
);

   iso8583u_pkg::state_type state_ff, state_in;
   logic from_start_ff, from_start_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= iso8583u_pkg::ST_READY;
         from_start_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         from_start_ff <= from_start_in;
      end
   end

   always_comb begin
      cmd = '0;
      state_in = state_ff;
      from_start_in = from_start_ff;
      req_stall = state_ff != iso8583u_pkg::ST_READY;
      unique case (state_ff)
         iso8583u_pkg::ST_READY: begin
            if (req_valid) begin
               if (status.req_is_msg) begin
                  cmd.capture = 1'b1;
                  state_in = iso8583u_pkg::ST_BEGIN;
               end else begin
                  cmd.table_wr = 1'b1;
               end
            end
         end
         iso8583u_pkg::ST_BEGIN: begin
            if (status.phase == iso8583u_pkg::PH_IDLE) begin
               cmd.msg_start = 1'b1;
               cmd.srch_init = 1'b1;
               from_start_in = 1'b1;
               state_in = iso8583u_pkg::ST_SEARCH;
            end else begin
               state_in = iso8583u_pkg::ST_DISPATCH;
            end
         end
         iso8583u_pkg::ST_SEARCH: begin
            cmd.srch_step = 1'b1;
            if (status.srch_done) begin
               if (status.srch_found) begin
                  cmd.set_cur = 1'b1;
                  state_in = iso8583u_pkg::ST_LOAD;
               end else begin
                  cmd.set_phase = 1'b1;
                  cmd.phase_val = iso8583u_pkg::PH_DONE;
                  state_in = from_start_ff ? iso8583u_pkg::ST_DISPATCH : iso8583u_pkg::ST_LAST;
               end
            end
         end
         iso8583u_pkg::ST_LOAD: begin
            cmd.load_entry = 1'b1;
            state_in = iso8583u_pkg::ST_START;
         end
         iso8583u_pkg::ST_START: begin
            if (status.start_fail) begin
               state_in = iso8583u_pkg::ST_FAIL;
            end else begin
               if (status.start_hdr) begin
                  cmd.set_phase = 1'b1;
                  cmd.phase_val = iso8583u_pkg::PH_HDR_A;
               end else begin
                  cmd.start_data = 1'b1;
               end
               state_in = from_start_ff ? iso8583u_pkg::ST_DISPATCH : iso8583u_pkg::ST_LAST;
            end
         end
         iso8583u_pkg::ST_FAIL: begin
            if (status.slot_free) begin
               cmd.emit = 1'b1;
               cmd.emit_sel = iso8583u_pkg::EMIT_FAIL;
               cmd.set_phase = 1'b1;
               cmd.phase_val = iso8583u_pkg::PH_ERROR;
               state_in = iso8583u_pkg::ST_LAST;
            end
         end
         iso8583u_pkg::ST_DISPATCH: begin
            unique case (status.phase)
               iso8583u_pkg::PH_HDR_A, iso8583u_pkg::PH_HDR_B,
               iso8583u_pkg::PH_HDR_B_STOP: begin
                  cmd.hdr_init = 1'b1;
                  state_in = iso8583u_pkg::ST_HDR_HI;
               end
               iso8583u_pkg::PH_DATA: state_in = iso8583u_pkg::ST_DATA;
               iso8583u_pkg::PH_DONE: begin
                  cmd.set_phase = 1'b1;
                  cmd.phase_val = iso8583u_pkg::PH_OVER;
                  state_in = iso8583u_pkg::ST_LAST;
               end
               default: state_in = iso8583u_pkg::ST_LAST;
            endcase
         end
         iso8583u_pkg::ST_HDR_HI: begin
            cmd.hdr_nib = 1'b1;
            state_in = iso8583u_pkg::ST_HDR_LO;
         end
         iso8583u_pkg::ST_HDR_LO: begin
            cmd.hdr_nib = 1'b1;
            cmd.hdr_lo = 1'b1;
            state_in = iso8583u_pkg::ST_HDR_END;
         end
         iso8583u_pkg::ST_HDR_END: begin
            if (status.phase == iso8583u_pkg::PH_HDR_A && status.hdr_fmt2) begin
               cmd.set_phase = 1'b1;
               cmd.phase_val = status.hdr_stop ? iso8583u_pkg::PH_HDR_B_STOP
                                               : iso8583u_pkg::PH_HDR_B;
               state_in = iso8583u_pkg::ST_LAST;
            end else if (status.hdr_bad) begin
               state_in = iso8583u_pkg::ST_FAIL;
            end else begin
               cmd.begin_hdr = 1'b1;
               state_in = iso8583u_pkg::ST_LAST;
            end
         end
         iso8583u_pkg::ST_DATA: begin
            cmd.data_step = 1'b1;
            unique case (status.data_cls)
               iso8583u_pkg::CLS_HEX: state_in = iso8583u_pkg::ST_HEX1;
               iso8583u_pkg::CLS_BCD: state_in = iso8583u_pkg::ST_BCD1;
               default:               state_in = iso8583u_pkg::ST_RAW;
            endcase
         end
         iso8583u_pkg::ST_HEX1: begin
            if (status.slot_free) begin
               cmd.emit = 1'b1;
               cmd.emit_sel = iso8583u_pkg::EMIT_HEX_HI;
               state_in = iso8583u_pkg::ST_HEX2;
            end
         end
         iso8583u_pkg::ST_HEX2: begin
            if (status.slot_free) begin
               cmd.emit = 1'b1;
               cmd.emit_sel = iso8583u_pkg::EMIT_HEX_LO;
               state_in = iso8583u_pkg::ST_FIELD_END;
            end
         end
         iso8583u_pkg::ST_RAW: begin
            if (status.slot_free) begin
               cmd.emit = 1'b1;
               cmd.emit_sel = iso8583u_pkg::EMIT_RAW;
               state_in = iso8583u_pkg::ST_FIELD_END;
            end
         end
         iso8583u_pkg::ST_BCD1: begin
            if (status.digits_zero) begin
               state_in = iso8583u_pkg::ST_BCD2;
            end else if (status.slot_free) begin
               cmd.emit = 1'b1;
               cmd.emit_sel = iso8583u_pkg::EMIT_BCD_HI;
               state_in = iso8583u_pkg::ST_BCD2;
            end
         end
         iso8583u_pkg::ST_BCD2: begin
            if (status.digits_zero) begin
               state_in = iso8583u_pkg::ST_FIELD_END;
            end else if (status.slot_free) begin
               cmd.emit = 1'b1;
               cmd.emit_sel = iso8583u_pkg::EMIT_BCD_LO;
               state_in = iso8583u_pkg::ST_FIELD_END;
            end
         end
         iso8583u_pkg::ST_FIELD_END: begin
            if (!status.bytes_zero) begin
               state_in = iso8583u_pkg::ST_LAST;
            end else if (status.mac_done) begin
               cmd.set_phase = 1'b1;
               cmd.phase_val = iso8583u_pkg::PH_DONE;
               state_in = iso8583u_pkg::ST_LAST;
            end else begin
               cmd.srch_init = 1'b1;
               cmd.srch_next = 1'b1;
               from_start_in = 1'b0;
               state_in = iso8583u_pkg::ST_SEARCH;
            end
         end
         iso8583u_pkg::ST_LAST: begin
            if (!status.last) begin
               state_in = iso8583u_pkg::ST_READY;
            end else if (status.error_seen) begin
               cmd.set_phase = 1'b1;
               cmd.phase_val = iso8583u_pkg::PH_IDLE;
               state_in = iso8583u_pkg::ST_READY;
            end else if (status.slot_free) begin
               cmd.emit = 1'b1;
               cmd.emit_sel = iso8583u_pkg::EMIT_STATUS;
               cmd.set_phase = 1'b1;
               cmd.phase_val = iso8583u_pkg::PH_IDLE;
               state_in = iso8583u_pkg::ST_READY;
            end
         end
         default: state_in = iso8583u_pkg::ST_READY;
      endcase
   end

endmodule

// ----- rtl/iso8583_message_unpacker.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// iso8583_message_unpacker
// parses iso 8583 style messages byte by byte against a loaded field table
// ---------------------------------------------------------------------------
// channel   direction  handshake            payload
// req       in         req_valid/req_stall  req_payload_type (table write or byte)
// rsp       out        rsp_valid/rsp_stall  rsp_payload_type (character or status)
// csr       in         csr_write            csr_index, csr_wdata
//
// a table write does not stall the request channel; a message byte holds
// req_stall until the sequencer returns to ready, and each result waits while the result register is full
// moving to the next field adds a search (8 indexes per
// cycle over the presence and defined bits) plus a registered table read
// synchronous reset clears the table valid bits, parse state and registers
// a stalled result holds the sequencer only where it must emit the next one
// ---------------------------------------------------------------------------
`include "iso8583_message_unpacker_macros.svh"

module iso8583_message_unpacker #(
   parameter int MAX_FIELDS = 128,
   parameter int MAX_BITMAP_BYTES = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  iso8583u_pkg::req_payload_type req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output iso8583u_pkg::rsp_payload_type rsp_data,
   input  logic                          csr_write,
   input  logic [1:0]                    csr_index,
   input  logic [7:0]                    csr_wdata
);

   // command and status between sequencer and datapath
   iso8583u_pkg::cmd_type    cmd;
   iso8583u_pkg::status_type status;

   // sequencer: one request at a time
   iso8583u_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: table, parse registers, search and result register
   iso8583u_dpath #(
      .MAX_FIELDS       (MAX_FIELDS),
      .MAX_BITMAP_BYTES (MAX_BITMAP_BYTES)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // a result is only loaded when the result register can take it
   `IMU_ASSERT_IMPLIES(a_emit_slot_free, clock, reset, cmd.emit, status.slot_free)
   // an accepted byte keeps the input side busy
   `IMU_ASSERT_NEXT(a_busy_after_byte, clock, reset, cmd.capture, req_stall)
   // entry load always follows a search hit
   `IMU_ASSERT_IMPLIES(a_load_after_hit, clock, reset, cmd.load_entry, $past(cmd.set_cur))

endmodule

// ----- bench/tb_iso8583_message_unpacker.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_iso8583_message_unpacker
// self-checking bench for the iso 8583 message unpacker: a short directed
// table, then random field tables and mostly well-formed messages over
// several register settings, every result checked against a local predictor
// ---------------------------------------------------------------------------
module tb_iso8583_message_unpacker;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   iso8583u_pkg::req_payload_type req_data = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   iso8583u_pkg::rsp_payload_type rsp_data;
   logic                          csr_write = 1'b0;
   logic [1:0]                    csr_index = iso8583u_pkg::CSR_BITMAP_FIELD;
   logic [7:0]                    csr_wdata = '0;

   iso8583_message_unpacker dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_write(csr_write), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow copy of the parser state
   logic [19:0]             fld_tab [128];
   logic [127:0]            pres_map;
   logic [6:0]              cur_fld;
   iso8583u_pkg::phase_type ph;
   logic [13:0]             hdr_val, bytes_rem, digits_rem;
   bit                      err_flag;
   logic [6:0]              cfg_bmf = 7'd1, cfg_macf = 7'd64;
   logic                    cfg_mace = 1'b0;
   logic [7:0]              cfg_total = 8'd128;
   logic [7:0]              hdr_low;
   string                   hex_set = "0123456789ABCDEF";

   iso8583u_pkg::rsp_payload_type step_res[$];     // results of the request being predicted
   iso8583u_pkg::rsp_payload_type pending_out[$];  // results still owed by the block

   int  n_bad = 0, n_checked = 0, n_items = 0, cyc = 0;
   bit  quiet = 1'b0, hold_ask = 1'b0, hold_served = 1'b0;
   int  hold_left = 0, burst_left = 0;

   // ---------------- predictor ----------------
   function automatic void put_res(logic [1:0] k, logic [6:0] f, logic [7:0] c, logic e);
      if (step_res.size() < 3) step_res.push_back('{k, f, c, e});
   endfunction

   function automatic void raise_len_err();
      put_res(iso8583u_pkg::KIND_LEN_ERROR, cur_fld, 8'd0, 1'b0);
      ph = iso8583u_pkg::PH_ERROR;
      err_flag = 1'b1;
   endfunction

   // priority search: defined fields before the bitmap, the bitmap, then
   // defined fields whose presence bit is set
   function automatic int next_field(int from);
      int lim;
      logic [19:0] e;
      lim = (cfg_total > 8'd128) ? 128 : int'(cfg_total);
      for (int i = from; i < 128; i++) begin
         e = fld_tab[i];
         if (i < cfg_bmf) begin
            if (e[19]) return i;
         end else if (i == cfg_bmf) begin
            return i;
         end else begin
            if (i >= lim) break;
            if (e[19] && pres_map[(i - 1) & 127]) return i;
         end
      end
      return -1;
   endfunction

   function automatic void open_data(int len);
      logic [19:0] e;
      e = fld_tab[cur_fld];
      if (cur_fld != cfg_bmf && e[18:16] == iso8583u_pkg::TYPE_BCD) begin
         digits_rem = 14'(len);
         bytes_rem = 14'((len + 1) / 2);
      end else begin
         digits_rem = '0;
         bytes_rem = 14'(len);
      end
      ph = iso8583u_pkg::PH_DATA;
   endfunction

   function automatic void open_field(int i);
      logic [19:0] e;
      logic [13:0] ln;
      e = fld_tab[i];
      ln = e[13:0];
      cur_fld = 7'(i);
      hdr_val = '0;
      if (i == cfg_bmf) begin
         if (!e[19] || e[15:14] != iso8583u_pkg::FMT_FIXED || ln == 0 || ln > 16)
            raise_len_err();
         else open_data(ln);
      end else if (e[18:16] > iso8583u_pkg::TYPE_MAC || e[15:14] > iso8583u_pkg::FMT_LLLVAR)
      begin
         raise_len_err();
      end else if (e[15:14] == iso8583u_pkg::FMT_FIXED) begin
         if (ln == 0) raise_len_err();
         else open_data(ln);
      end else begin
         ph = iso8583u_pkg::PH_HDR_A;
      end
   endfunction

   function automatic void close_field();
      int k;
      if (cfg_mace && cur_fld == cfg_macf && cur_fld > cfg_bmf) begin
         ph = iso8583u_pkg::PH_DONE;
         return;
      end
      k = next_field(int'(cur_fld) + 1);
      if (k < 0) ph = iso8583u_pkg::PH_DONE;
      else open_field(k);
   endfunction

   function automatic void hdr_digit(logic [3:0] nib, inout bit stop);
      if (stop) return;
      if (nib > 4'd9) stop = 1'b1;
      else hdr_val = 14'(int'(hdr_val) * 10 + int'(nib));
   endfunction

   function automatic void close_hdr();
      logic [13:0] ln;
      ln = fld_tab[cur_fld][13:0];
      if (hdr_val == 0 || hdr_val > ln) raise_len_err();
      else open_data(int'(hdr_val));
   endfunction

   function automatic void take_data(logic [7:0] b);
      logic [19:0] e;
      logic [2:0] t;
      int kb;
      bit fin;
      e = fld_tab[cur_fld];
      t = e[18:16];
      if (cur_fld == cfg_bmf) begin
         // bitmap byte k covers presence bits k*8 .. k*8+7, msb first
         kb = int'((e[13:0] - bytes_rem) & 14'd15);
         for (int s = 0; s < 8; s++)
            if (b[7 - s]) pres_map[kb * 8 + s] = 1'b1;
         t = iso8583u_pkg::TYPE_BITMAP;
      end
      bytes_rem = bytes_rem - 14'd1;
      fin = (bytes_rem == 0);
      if (t == iso8583u_pkg::TYPE_BIN || t == iso8583u_pkg::TYPE_MAC) begin
         put_res(iso8583u_pkg::KIND_CHAR, cur_fld, 8'(hex_set[b[7:4]]), 1'b0);
         put_res(iso8583u_pkg::KIND_CHAR, cur_fld, 8'(hex_set[b[3:0]]), fin);
      end else if (t == iso8583u_pkg::TYPE_BCD) begin
         if (digits_rem > 0) begin
            digits_rem = digits_rem - 14'd1;
            put_res(iso8583u_pkg::KIND_CHAR, cur_fld, 8'h30 + {4'd0, b[7:4]},
                    digits_rem == 0);
         end
         if (digits_rem > 0) begin
            digits_rem = digits_rem - 14'd1;
            put_res(iso8583u_pkg::KIND_CHAR, cur_fld, 8'h30 + {4'd0, b[3:0]},
                    digits_rem == 0);
         end
      end else begin
         put_res(iso8583u_pkg::KIND_CHAR, cur_fld, b, fin);
      end
      if (fin) close_field();
   endfunction

   // everything a message byte does except the last-byte status
   function automatic void consume_byte(logic [7:0] b);
      bit stop;
      int k;
      step_res.delete();
      if (ph == iso8583u_pkg::PH_IDLE) begin
         pres_map = '0;
         err_flag = 1'b0;
         k = next_field(0);
         if (k < 0) ph = iso8583u_pkg::PH_DONE;
         else open_field(k);
         if (ph == iso8583u_pkg::PH_ERROR) return;
      end
      case (ph)
         iso8583u_pkg::PH_HDR_A: begin
            stop = 1'b0;
            hdr_digit(b[7:4], stop);
            hdr_digit(b[3:0], stop);
            if (fld_tab[cur_fld][15:14] != iso8583u_pkg::FMT_LLLVAR) close_hdr();
            else ph = stop ? iso8583u_pkg::PH_HDR_B_STOP : iso8583u_pkg::PH_HDR_B;
         end
         iso8583u_pkg::PH_HDR_B, iso8583u_pkg::PH_HDR_B_STOP: begin
            stop = (ph == iso8583u_pkg::PH_HDR_B_STOP);
            hdr_digit(b[7:4], stop);
            hdr_digit(b[3:0], stop);
            close_hdr();
         end
         iso8583u_pkg::PH_DATA: take_data(b);
         iso8583u_pkg::PH_DONE: ph = iso8583u_pkg::PH_OVER;
         default: ;
      endcase
   endfunction

   function automatic void close_request(bit last);
      if (last) begin
         if (!err_flag)
            put_res((ph == iso8583u_pkg::PH_DONE) ? iso8583u_pkg::KIND_OK
                                                  : iso8583u_pkg::KIND_MISMATCH,
                    7'd0, 8'd0, 1'b0);
         ph = iso8583u_pkg::PH_IDLE;
      end
   endfunction

   function automatic void table_write(iso8583u_pkg::req_payload_type p);
      step_res.delete();
      fld_tab[p.def_index] = {p.def_present, p.def_type, p.def_format, p.def_length};
   endfunction

   // ---------------- request builders ----------------
   function automatic iso8583u_pkg::req_payload_type mk_tab(int idx, bit pres, int typ,
                                                            int fmt, int len);
      iso8583u_pkg::req_payload_type p;
      p = '0;
      p.req_type = iso8583u_pkg::REQ_TABLE;
      p.def_index = 7'(idx);
      p.def_present = pres;
      p.def_type = 3'(typ);
      p.def_format = 2'(fmt);
      p.def_length = 14'(len);
      return p;
   endfunction

   function automatic iso8583u_pkg::req_payload_type mk_byte(logic [7:0] b, bit last);
      iso8583u_pkg::req_payload_type p;
      p = '0;
      p.req_type = iso8583u_pkg::REQ_MSG;
      p.msg_byte = b;
      p.last_byte = last;
      return p;
   endfunction

   function automatic iso8583u_pkg::req_payload_type rand_entry(int idx);
      int r;
      r = $urandom_range(0, 29);
      return mk_tab(idx, $urandom_range(0, 9) < 8,
                    ($urandom_range(0, 19) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 4),
                    ($urandom_range(0, 19) == 0) ? 3 : $urandom_range(0, 2),
                    (r == 0) ? 0 : (r == 1) ? 9999 : (r == 2) ? $urandom_range(0, 16383)
                                                            : $urandom_range(1, 6));
   endfunction

   // mostly a valid length header where one is due, random content otherwise
   function automatic logic [7:0] pick_byte();
      int k, f, cap, len;
      bit want_hdr;
      logic [19:0] e;
      want_hdr = 1'b0;
      f = cur_fld;
      if (ph == iso8583u_pkg::PH_HDR_B) return hdr_low;
      if (ph == iso8583u_pkg::PH_HDR_A) begin
         want_hdr = 1'b1;
      end else if (ph == iso8583u_pkg::PH_IDLE) begin
         k = next_field(0);
         if (k >= 0 && k != cfg_bmf &&
             (fld_tab[k][15:14] == iso8583u_pkg::FMT_LLVAR ||
              fld_tab[k][15:14] == iso8583u_pkg::FMT_LLLVAR)) begin
            want_hdr = 1'b1;
            f = k;
         end
      end
      if (!want_hdr || $urandom_range(0, 12) == 0) return 8'($urandom_range(0, 255));
      e = fld_tab[f];
      cap = (e[13:0] < 6) ? int'(e[13:0]) : 6;
      if (cap == 0) return 8'h00;
      len = $urandom_range(1, cap);
      if (e[15:14] == iso8583u_pkg::FMT_LLVAR) return {4'd0, 4'(len)};
      hdr_low = {4'd0, 4'(len)};
      return 8'h00;
   endfunction

   // ---------------- drivers ----------------
   // queue the predicted results, then offer the request until accepted
   task automatic issue(iso8583u_pkg::req_payload_type p);
      foreach (step_res[i]) pending_out.push_back(step_res[i]);
      n_items++;
      req_data <= p;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
   endtask

   // sender pauses until the block owes nothing, then lets it settle
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_out.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic csr_put(logic [1:0] idx, logic [7:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         iso8583u_pkg::CSR_BITMAP_FIELD: cfg_bmf = val[6:0];
         iso8583u_pkg::CSR_MAC_FIELD:    cfg_macf = val[6:0];
         iso8583u_pkg::CSR_MAC_ENABLE:   cfg_mace = val[0];
         default:                        cfg_total = val;
      endcase
      @(posedge clock);
   endtask

   // ---------------- result checker and receiver stalls ----------------
   always @(posedge clock) begin
      iso8583u_pkg::rsp_payload_type w;
      if (!reset && rsp_valid && !rsp_stall) begin
         n_checked++;
         if (pending_out.size() == 0) begin
            $error("unexpected result kind %0d field %0d char %0h",
                   rsp_data.out_kind, rsp_data.field_number, rsp_data.out_char);
            n_bad++;
         end else begin
            w = pending_out.pop_front();
            if (rsp_data.out_kind !== w.out_kind) begin
               $error("out_kind exp %0d got %0d", w.out_kind, rsp_data.out_kind);
               n_bad++;
            end
            if (rsp_data.field_number !== w.field_number) begin
               $error("field_number exp %0d got %0d", w.field_number, rsp_data.field_number);
               n_bad++;
            end
            if (rsp_data.out_char !== w.out_char) begin
               $error("out_char exp %0h got %0h", w.out_char, rsp_data.out_char);
               n_bad++;
            end
            if (rsp_data.field_end !== w.field_end) begin
               $error("field_end exp %0d got %0d", w.field_end, rsp_data.field_end);
               n_bad++;
            end
         end
      end
      // one long hold-off on request, otherwise short random bursts
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (hold_ask && !hold_served) begin
         hold_left = 400;
         hold_served = 1'b1;
         rsp_stall <= 1'b1;
      end else if (burst_left > 0) begin
         burst_left--;
         rsp_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
         burst_left = $urandom_range(0, 17);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // watchdog
   always @(posedge clock) begin
      cyc++;
      if (cyc > 600000) begin
         $display("Verification failed");
         $finish;
      end
   end

   // ---------------- stimulus ----------------
   typedef struct {
      iso8583u_pkg::req_payload_type rq;
      bit                            typed;
      iso8583u_pkg::rsp_payload_type want;
   } dir_row_type;

   dir_row_type dir_rows[$];
   // bitmap_field, mac_field, mac_enable, field_total, bitmap length
   int cfgs [7][5] = '{'{1, 64, 0, 128, 2}, '{1, 12, 1, 128, 2}, '{0, 5, 1, 20, 1},
                      '{1, 9, 0, 2, 1}, '{127, 0, 0, 128, 16}, '{2, 127, 1, 200, 2},
                      '{3, 10, 1, 16, 2}};

   initial begin
      logic [7:0] b;
      bit last, msg_open;
      int msg_len, phase_items;
      iso8583u_pkg::rsp_payload_type none;
      iso8583u_pkg::req_payload_type tw;
      none = '0;
      foreach (fld_tab[i]) fld_tab[i] = '0;
      pres_map = '0;
      cur_fld = '0;
      ph = iso8583u_pkg::PH_IDLE;
      hdr_val = '0;
      bytes_rem = '0;
      digits_rem = '0;
      err_flag = 1'b0;

      // directed: empty table, a full message with ascii, bcd, binary and bitmap fields,
      // header errors and a bad table entry
      dir_rows.push_back('{mk_byte(8'h00, 1), 1,
                           '{iso8583u_pkg::KIND_LEN_ERROR, 7'd1, 8'd0, 1'b0}});
      dir_rows.push_back('{mk_tab(1, 1, iso8583u_pkg::TYPE_BITMAP, iso8583u_pkg::FMT_FIXED, 1),
                           0, none});
      dir_rows.push_back('{mk_tab(0, 1, iso8583u_pkg::TYPE_ASCII, iso8583u_pkg::FMT_FIXED, 1),
                           0, none});
      dir_rows.push_back('{mk_tab(2, 1, iso8583u_pkg::TYPE_BCD, iso8583u_pkg::FMT_LLVAR, 19),
                           0, none});
      dir_rows.push_back('{mk_tab(3, 1, iso8583u_pkg::TYPE_BIN, iso8583u_pkg::FMT_FIXED, 1),
                           0, none});
      dir_rows.push_back('{mk_tab(4, 1, iso8583u_pkg::TYPE_ASCII, iso8583u_pkg::FMT_LLLVAR,
                                  9999), 0, none});
      dir_rows.push_back('{mk_tab(127, 1, iso8583u_pkg::TYPE_MAC, iso8583u_pkg::FMT_FIXED,
                                  16383), 0, none});
      dir_rows.push_back('{mk_byte(8'h5A, 0), 0, none});
      dir_rows.push_back('{mk_byte(8'h70, 0), 0, none});  // fields 2, 3, 4
      dir_rows.push_back('{mk_byte(8'h03, 0), 0, none});  // three bcd digits
      dir_rows.push_back('{mk_byte(8'h12, 0), 0, none});
      dir_rows.push_back('{mk_byte(8'h3F, 0), 0, none});  // pad nibble trimmed
      dir_rows.push_back('{mk_byte(8'hAF, 0), 0, none});
      dir_rows.push_back('{mk_byte(8'h00, 0), 0, none});
      dir_rows.push_back('{mk_byte(8'h02, 0), 0, none});
      dir_rows.push_back('{mk_byte(8'h68, 0), 0, none});
      dir_rows.push_back('{mk_byte(8'hFF, 1), 0, none});
      dir_rows.push_back('{mk_byte(8'h78, 0), 0, none});
      dir_rows.push_back('{mk_byte(8'h40, 0), 0, none});
      dir_rows.push_back('{mk_byte(8'h00, 1), 1,
                           '{iso8583u_pkg::KIND_LEN_ERROR, 7'd2, 8'd0, 1'b0}});
      dir_rows.push_back('{mk_byte(8'h78, 0), 0, none});
      dir_rows.push_back('{mk_byte(8'h40, 0), 0, none});
      dir_rows.push_back('{mk_byte(8'h20, 1), 1,
                           '{iso8583u_pkg::KIND_LEN_ERROR, 7'd2, 8'd0, 1'b0}});
      dir_rows.push_back('{mk_tab(2, 1, 7, 3, 0), 0, none});
      dir_rows.push_back('{mk_byte(8'h31, 0), 0, none});
      dir_rows.push_back('{mk_byte(8'h40, 1), 0, none});

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i]) begin
         if (dir_rows[i].rq.req_type == iso8583u_pkg::REQ_TABLE) begin
            table_write(dir_rows[i].rq);
         end else begin
            consume_byte(dir_rows[i].rq.msg_byte);
            close_request(dir_rows[i].rq.last_byte);
         end
         if (dir_rows[i].typed) begin
            step_res.delete();
            step_res.push_back(dir_rows[i].want);
         end
         issue(dir_rows[i].rq);
      end

      // random phases, one register setting each
      for (int p = 0; p < 7; p++) begin
         settle();
         if (p == 6) quiet = 1'b1;
         csr_put(iso8583u_pkg::CSR_BITMAP_FIELD, 8'(cfgs[p][0]));
         csr_put(iso8583u_pkg::CSR_MAC_FIELD, 8'(cfgs[p][1]));
         csr_put(iso8583u_pkg::CSR_MAC_ENABLE, 8'(cfgs[p][2]));
         csr_put(iso8583u_pkg::CSR_FIELD_TOTAL, 8'(cfgs[p][3]));
         csr_write <= 1'b0;
         @(posedge clock);

         for (int i = 0; i < 18; i++) begin
            tw = rand_entry(i);
            table_write(tw);
            issue(tw);
         end
         // fixed up: the bitmap field sometimes malformed, the mac field sane
         if (cfgs[p][1] != cfgs[p][0]) begin
            table_write(mk_tab(cfgs[p][1], 1, iso8583u_pkg::TYPE_MAC, iso8583u_pkg::FMT_FIXED,
                               $urandom_range(1, 3)));
            issue(mk_tab(cfgs[p][1], 1, iso8583u_pkg::TYPE_MAC, iso8583u_pkg::FMT_FIXED,
                         fld_tab[cfgs[p][1]][13:0]));
         end
         if ($urandom_range(0, 9) == 0)
            table_write(mk_tab(cfgs[p][0], 1, iso8583u_pkg::TYPE_BITMAP,
                               $urandom_range(0, 1), 17));
         else
            table_write(mk_tab(cfgs[p][0], 1, iso8583u_pkg::TYPE_BITMAP,
                               iso8583u_pkg::FMT_FIXED, cfgs[p][4]));
         issue(mk_tab(cfgs[p][0], fld_tab[cfgs[p][0]][19], fld_tab[cfgs[p][0]][18:16],
                      fld_tab[cfgs[p][0]][15:14], fld_tab[cfgs[p][0]][13:0]));

         if (p == 1) hold_ask = 1'b1;  // receiver backs off while bytes keep coming
         msg_open = 1'b0;
         msg_len = 0;
         phase_items = 0;
         while (phase_items < 32 || msg_open) begin
            if ($urandom_range(0, 39) == 0) begin
               // live table change in the middle of a message
               tw = rand_entry($urandom_range(0, 17));
               table_write(tw);
               issue(tw);
            end
            b = pick_byte();
            consume_byte(b);
            msg_len++;
            last = (ph == iso8583u_pkg::PH_DONE && $urandom_range(0, 19) != 0) ||
                   (ph == iso8583u_pkg::PH_ERROR && $urandom_range(0, 2) != 0) ||
                   msg_len >= 40 || $urandom_range(0, 49) == 0;
            close_request(last);
            issue(mk_byte(b, last));
            msg_open = !last;
            if (last) msg_len = 0;
            phase_items++;
         end
      end

      req_valid <= 1'b0;
      while (pending_out.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      $display("ran %0d requests over 7 register settings plus a directed table", n_items);
      $display("checked %0d results, %0d mismatches", n_checked, n_bad);
      if (n_bad == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
